// ===== rtl/dc_motor_rk4_plant_step_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the DC motor plant step.
// Each macro checks an implication on the rising edge of clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DC_MOTOR_RK4_PLANT_STEP_MACROS_SVH
`define DC_MOTOR_RK4_PLANT_STEP_MACROS_SVH

// Same-cycle implication.
`define DCM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dcm_rk4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_rk4_pkg
// Widths, register map, control word format and microcode for the DC motor
// plant step.
// ----------------------------------------------------------------------------
package dcm_rk4_pkg;

  // Width of the stored speed and current.
  localparam int STATE_BITS = 32;

  localparam int WIDE_W    = 64;
  localparam int MAG_W     = WIDE_W - 1;
  localparam int COEF_W    = 31;
  localparam int LOAD_W    = 32;
  localparam int CFG_W     = 32;
  localparam int VOLT_W    = 23;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Multiplier split: the magnitude is multiplied in a low and a high half.
  localparam int LO_BITS    = 32;
  localparam int HI_BITS    = MAG_W - LO_BITS;
  localparam int PROD_LO_W  = LO_BITS + COEF_W;
  localparam int PROD_HI_W  = HI_BITS + COEF_W;
  localparam int FULL_W     = PROD_HI_W + LO_BITS + 1;
  localparam int MUL_SHIFT  = 24;

  // Divide by six, several quotient bits per cycle.
  localparam int DIVISOR   = 6;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = WIDE_W / DIV_BITS;
  localparam int REM_W     = 3;

  localparam int PH_W = $clog2(DIV_STEPS + 2);
  localparam logic [PH_W-1:0] MUL_PH_ABS  = PH_W'(0);
  localparam logic [PH_W-1:0] MUL_PH_LO   = PH_W'(1);
  localparam logic [PH_W-1:0] MUL_PH_HI   = PH_W'(2);
  localparam logic [PH_W-1:0] MUL_PH_SUM  = PH_W'(3);
  localparam logic [PH_W-1:0] MUL_PH_WR   = PH_W'(4);
  localparam logic [PH_W-1:0] DIV_PH_INIT = PH_W'(0);
  localparam logic [PH_W-1:0] DIV_PH_WR   = PH_W'(DIV_STEPS + 1);

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = -WIDE_MAX;

  // Register map.
  localparam logic [CFG_IDX_W-1:0] CFG_INV_INERTIA    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INV_INDUCTANCE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RESISTANCE     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_CONST   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_TORQUE    = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = CFG_IDX_W'(6);

  localparam logic [COEF_W-1:0] RST_INV_INERTIA    = 31'd335544320;
  localparam logic [COEF_W-1:0] RST_INV_INDUCTANCE = 31'd167772160;
  localparam logic [COEF_W-1:0] RST_RESISTANCE     = 31'd3355443;
  localparam logic [COEF_W-1:0] RST_FRICTION       = 31'd16777;
  localparam logic [COEF_W-1:0] RST_TORQUE_CONST   = 31'd8388608;
  localparam logic signed [LOAD_W-1:0] RST_LOAD_TORQUE = 32'sd3355443;
  localparam logic [COEF_W-1:0] RST_TIME_STEP      = 31'd167772;

  // Multiplying a Q8.24 value by 2^16 and dropping 24 bits gives Q16.16.
  localparam logic [COEF_W-1:0] COEF_ONE16 = 31'h0001_0000;

  // Microcode.
  typedef enum logic [2:0] {
    OP_WAIT, OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_JMP, OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS, COND_FIRST, COND_LAST
  } cond_t;

  typedef enum logic [3:0] {
    R_ZERO, R_W, R_I, R_V, R_LD, R_LDRAW, R_TW, R_TI,
    R_T, R_U, R_KW, R_KI, R_SW, R_SI
  } reg_t;

  typedef enum logic [2:0] {
    C_INVJ, C_INVL, C_RES, C_FRIC, C_KT, C_STEP, C_ONE16
  } coef_t;

  typedef enum logic [1:0] {
    SH_24, SH_25, SH_STAGE
  } shift_t;

  localparam int PROG_LEN = 34;
  localparam int PC_W     = $clog2(PROG_LEN);

  localparam logic [PC_W-1:0] PC_WAIT       = PC_W'(0);
  localparam logic [PC_W-1:0] PC_SLOPES     = PC_W'(2);
  localparam logic [PC_W-1:0] PC_ACCUM      = PC_W'(18);
  localparam logic [PC_W-1:0] PC_COPY       = PC_W'(22);
  localparam logic [PC_W-1:0] PC_NEXT_STAGE = PC_W'(24);
  localparam logic [PC_W-1:0] PC_FINISH     = PC_W'(29);

  localparam logic [1:0] STG_LAST = 2'd3;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic             stg_inc;
    reg_t             dst;
    reg_t             srca;
    reg_t             srcb;
    coef_t            coef;
    shift_t           sh;
  } ctrl_t;

  function automatic ctrl_t cw_simple(input op_t op);
    ctrl_t w;
    w    = '0;
    w.op = op;
    return w;
  endfunction

  function automatic ctrl_t cw_mul(input reg_t dst, input reg_t a, input coef_t c,
                                   input shift_t sh);
    ctrl_t w;
    w      = '0;
    w.op   = OP_MUL;
    w.dst  = dst;
    w.srca = a;
    w.coef = c;
    w.sh   = sh;
    return w;
  endfunction

  function automatic ctrl_t cw_alu(input op_t op, input reg_t dst, input reg_t a,
                                   input reg_t b);
    ctrl_t w;
    w      = '0;
    w.op   = op;
    w.dst  = dst;
    w.srca = a;
    w.srcb = b;
    return w;
  endfunction

  function automatic ctrl_t cw_div(input reg_t dst, input reg_t a);
    ctrl_t w;
    w      = '0;
    w.op   = OP_DIV;
    w.dst  = dst;
    w.srca = a;
    return w;
  endfunction

  function automatic ctrl_t cw_jmp(input cond_t cond, input logic [PC_W-1:0] tgt,
                                   input logic inc);
    ctrl_t w;
    w         = '0;
    w.op      = OP_JMP;
    w.cond    = cond;
    w.target  = tgt;
    w.stg_inc = inc;
    return w;
  endfunction

  // The program. Steps 2 to 28 form the stage loop, run four times.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (int'(pc))
      0:  w = cw_simple(OP_WAIT);
      1:  w = cw_mul(R_LD, R_LDRAW, C_ONE16, SH_24);
      // Speed slope.
      2:  w = cw_mul(R_T, R_TI, C_KT, SH_24);
      3:  w = cw_mul(R_U, R_TW, C_FRIC, SH_24);
      4:  w = cw_alu(OP_SUB, R_T, R_T, R_U);
      5:  w = cw_alu(OP_SUB, R_T, R_T, R_LD);
      6:  w = cw_mul(R_KW, R_T, C_INVJ, SH_24);
      // Current slope.
      7:  w = cw_mul(R_U, R_TW, C_KT, SH_24);
      8:  w = cw_alu(OP_SUB, R_T, R_V, R_U);
      9:  w = cw_mul(R_U, R_TI, C_RES, SH_24);
      10: w = cw_alu(OP_SUB, R_T, R_T, R_U);
      11: w = cw_mul(R_KI, R_T, C_INVL, SH_24);
      // Increments for the weighted sum.
      12: w = cw_mul(R_U, R_KW, C_STEP, SH_24);
      13: w = cw_mul(R_T, R_KI, C_STEP, SH_24);
      14: w = cw_jmp(COND_FIRST, PC_COPY, 1'b0);
      15: w = cw_jmp(COND_LAST, PC_ACCUM, 1'b0);
      16: w = cw_alu(OP_ADD, R_U, R_U, R_U);
      17: w = cw_alu(OP_ADD, R_T, R_T, R_T);
      18: w = cw_alu(OP_ADD, R_SW, R_SW, R_U);
      19: w = cw_alu(OP_ADD, R_SI, R_SI, R_T);
      20: w = cw_jmp(COND_LAST, PC_FINISH, 1'b0);
      21: w = cw_jmp(COND_ALWAYS, PC_NEXT_STAGE, 1'b0);
      22: w = cw_alu(OP_ADD, R_SW, R_U, R_ZERO);
      23: w = cw_alu(OP_ADD, R_SI, R_T, R_ZERO);
      // Inputs of the next stage.
      24: w = cw_mul(R_U, R_KW, C_STEP, SH_STAGE);
      25: w = cw_alu(OP_ADD, R_TW, R_W, R_U);
      26: w = cw_mul(R_U, R_KI, C_STEP, SH_STAGE);
      27: w = cw_alu(OP_ADD, R_TI, R_I, R_U);
      28: w = cw_jmp(COND_ALWAYS, PC_SLOPES, 1'b1);
      // New state.
      29: w = cw_div(R_U, R_SW);
      30: w = cw_alu(OP_ADD, R_W, R_W, R_U);
      31: w = cw_div(R_U, R_SI);
      32: w = cw_alu(OP_ADD, R_I, R_I, R_U);
      33: w = cw_simple(OP_OUT);
      default: w = cw_simple(OP_WAIT);
    endcase
    return w;
  endfunction

  // Saturate a wide signed value to a signed range of the given width.
  function automatic logic signed [WIDE_W-1:0] clamp_to(
    input logic signed [WIDE_W-1:0] a, input int bits);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = (WIDE_W'(1) << (bits - 1)) - WIDE_W'(1);
    lo = -hi - WIDE_W'(1);
    if (a > hi) begin
      return hi;
    end else if (a < lo) begin
      return lo;
    end
    return a;
  endfunction

endpackage

// ===== rtl/dc_motor_rk4_plant_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dc_motor_rk4_plant_step
// DC motor plant model: one fourth-order Runge-Kutta step of rotor speed and
// winding current per input beat, run by a microcoded fixed-point datapath.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                  Direction  Beat
//  -------  ---------------------------------------  ---------  ----------------
//  in       in_valid, in_ready, in_drive_voltage      sink       one tick
//  out      out_valid, out_ready, out_speed_out,      source     one new state
//           out_current_out
//  cfg      cfg_we, cfg_index, cfg_wdata              sink       one register
//
// An item goes from acceptance to its result through 39 products (phases:
// absolute value, low half, high half, sum, write), two divide-by-six passes,
// and the adds and jumps.
// in_ready is high only while the sequencer sits at its wait step.
// Synchronous active-low reset zeroes speed and current and loads the
// register defaults.
// A result waits in the output register; the next item is accepted and
// computed meanwhile, and the sequencer holds at its output step only while
// the previous result is still untaken.
`include "dc_motor_rk4_plant_step_macros.svh"

module dc_motor_rk4_plant_step
  import dcm_rk4_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VOLT_W-1:0]  in_drive_voltage,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   out_speed_out,
  output logic signed [OUT_W-1:0]   out_current_out,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  // --------------------------------------------------------------------------
  // Configuration registers. They are only to be written while the block is idle; the block does not check this.
  // --------------------------------------------------------------------------
  logic [COEF_W-1:0]        inv_j_r, inv_l_r, res_r, fric_r, kt_r, step_r;
  logic signed [LOAD_W-1:0] load_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_j_r <= RST_INV_INERTIA;
      inv_l_r <= RST_INV_INDUCTANCE;
      res_r   <= RST_RESISTANCE;
      fric_r  <= RST_FRICTION;
      kt_r    <= RST_TORQUE_CONST;
      load_r  <= RST_LOAD_TORQUE;
      step_r  <= RST_TIME_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_INERTIA:    inv_j_r <= cfg_wdata[COEF_W-1:0];
        CFG_INV_INDUCTANCE: inv_l_r <= cfg_wdata[COEF_W-1:0];
        CFG_RESISTANCE:     res_r   <= cfg_wdata[COEF_W-1:0];
        CFG_FRICTION:       fric_r  <= cfg_wdata[COEF_W-1:0];
        CFG_TORQUE_CONST:   kt_r    <= cfg_wdata[COEF_W-1:0];
        CFG_LOAD_TORQUE:    load_r  <= cfg_wdata[LOAD_W-1:0];
        CFG_TIME_STEP:      step_r  <= cfg_wdata[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: step counter, phase counter for the multi-cycle units and the
  // Runge-Kutta stage counter that the conditional jumps test.
  // --------------------------------------------------------------------------
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [PH_W-1:0] ph_r, ph_nxt;
  logic [1:0]      stg_r, stg_nxt;
  ctrl_t           cw;
  logic            taken;

  assign cw = ucode(pc_r);

  // --------------------------------------------------------------------------
  // Datapath registers. All intermediates are 64-bit signed Q16.16 values
  // that saturate at plus or minus (2^63 - 1).
  // --------------------------------------------------------------------------
  logic signed [STATE_BITS-1:0] w_r, w_nxt, i_r, i_nxt;
  logic signed [VOLT_W-1:0]     v_r, v_nxt;
  logic signed [WIDE_W-1:0]     ld_r, ld_nxt, tw_r, tw_nxt, ti_r, ti_nxt;
  logic signed [WIDE_W-1:0]     t_r, t_nxt, u_r, u_nxt, kw_r, kw_nxt, ki_r, ki_nxt;
  logic signed [WIDE_W-1:0]     sw_r, sw_nxt, si_r, si_nxt;

  // Multiplier: magnitude, sign, two partial products and the rounded result.
  logic [MAG_W-1:0]     m_r, m_nxt;
  logic                 neg_r, neg_nxt;
  logic [PROD_LO_W-1:0] plo_r, plo_nxt;
  logic [PROD_HI_W-1:0] phi_r, phi_nxt;
  logic [MAG_W-1:0]     mr_r, mr_nxt;

  // Divider: dividend shifting out at the top while quotient bits enter below.
  logic [WIDE_W-1:0] dq_r, dq_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;

  logic signed [WIDE_W-1:0] w_wide, i_wide;
  logic signed [WIDE_W-1:0] a_val, b_val;
  logic [WIDE_W-1:0]        a_abs;
  logic [COEF_W-1:0]        coef_val;
  logic                     use25;
  logic signed [WIDE_W:0]   a_ext, b_ext, sum_ext;
  logic signed [WIDE_W-1:0] sat_val;
  logic [FULL_W-1:0]        full, shifted, half;
  logic [REM_W:0]           dr;
  logic [WIDE_W-1:0]        dqs, q_rnd;
  logic                     wr_en;
  logic signed [WIDE_W-1:0] wr_val;

  logic                     out_valid_r, out_valid_nxt, out_load;
  logic signed [OUT_W-1:0]  out_speed_r, out_speed_nxt, out_current_r, out_current_nxt;

  assign w_wide = WIDE_W'(w_r);
  assign i_wide = WIDE_W'(i_r);

  assign in_ready = (cw.op == OP_WAIT);

  // Operand selection.
  always_comb begin
    case (cw.srca)
      R_W:     a_val = w_wide;
      R_I:     a_val = i_wide;
      R_V:     a_val = WIDE_W'(v_r);
      R_LD:    a_val = ld_r;
      R_LDRAW: a_val = WIDE_W'(load_r);
      R_TW:    a_val = tw_r;
      R_TI:    a_val = ti_r;
      R_T:     a_val = t_r;
      R_U:     a_val = u_r;
      R_KW:    a_val = kw_r;
      R_KI:    a_val = ki_r;
      R_SW:    a_val = sw_r;
      R_SI:    a_val = si_r;
      default: a_val = '0;
    endcase
  end

  always_comb begin
    case (cw.srcb)
      R_W:     b_val = w_wide;
      R_I:     b_val = i_wide;
      R_V:     b_val = WIDE_W'(v_r);
      R_LD:    b_val = ld_r;
      R_LDRAW: b_val = WIDE_W'(load_r);
      R_TW:    b_val = tw_r;
      R_TI:    b_val = ti_r;
      R_T:     b_val = t_r;
      R_U:     b_val = u_r;
      R_KW:    b_val = kw_r;
      R_KI:    b_val = ki_r;
      R_SW:    b_val = sw_r;
      R_SI:    b_val = si_r;
      default: b_val = '0;
    endcase
  end

  always_comb begin
    case (cw.coef)
      C_INVJ:  coef_val = inv_j_r;
      C_INVL:  coef_val = inv_l_r;
      C_RES:   coef_val = res_r;
      C_FRIC:  coef_val = fric_r;
      C_KT:    coef_val = kt_r;
      C_STEP:  coef_val = step_r;
      C_ONE16: coef_val = COEF_ONE16;
      default: coef_val = '0;
    endcase
  end

  // Half-step offsets drop one more bit. The first two stages feed the
  // half-step points; the third feeds the full step.
  assign use25 = (cw.sh == SH_25) || ((cw.sh == SH_STAGE) && !stg_r[1]);

  assign a_abs = a_val[WIDE_W-1] ? WIDE_W'(-a_val) : WIDE_W'(a_val);

  // Saturating add and subtract.
  assign a_ext   = (WIDE_W+1)'(a_val);
  assign b_ext   = (WIDE_W+1)'(b_val);
  assign sum_ext = (cw.op == OP_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);

  always_comb begin
    if (sum_ext > (WIDE_W+1)'(WIDE_MAX)) begin
      sat_val = WIDE_MAX;
    end else if (sum_ext < (WIDE_W+1)'(WIDE_MIN)) begin
      sat_val = WIDE_MIN;
    end else begin
      sat_val = sum_ext[WIDE_W-1:0];
    end
  end

  // Full product with round-half-up on the magnitude, which is round to
  // nearest with ties away from zero once the sign goes back on.
  assign half    = use25 ? (FULL_W'(1) << MUL_SHIFT) : (FULL_W'(1) << (MUL_SHIFT - 1));
  assign full    = (FULL_W'(phi_r) << LO_BITS) + FULL_W'(plo_r) + half;
  assign shifted = use25 ? (full >> (MUL_SHIFT + 1)) : (full >> MUL_SHIFT);

  // Divide-by-six digit step: DIV_BITS restoring steps on a remainder below six.
  always_comb begin
    dr  = {1'b0, rem_r};
    dqs = dq_r;
    for (int k = 0; k < DIV_BITS; k++) begin
      dr  = {dr[REM_W-1:0], dqs[WIDE_W-1]};
      dqs = {dqs[WIDE_W-2:0], 1'b0};
      if (dr >= (REM_W+1)'(DIVISOR)) begin
        dr     = dr - (REM_W+1)'(DIVISOR);
        dqs[0] = 1'b1;
      end
    end
  end

  // The quotient rounds up when the remainder is at least half the divisor.
  assign q_rnd = dq_r + WIDE_W'(rem_r >= REM_W'(DIVISOR / 2));

  // --------------------------------------------------------------------------
  // Next step.
  // --------------------------------------------------------------------------
  always_comb begin
    case (cw.cond)
      COND_ALWAYS: taken = 1'b1;
      COND_FIRST:  taken = (stg_r == 2'd0);
      COND_LAST:   taken = (stg_r == STG_LAST);
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt  = pc_r;
    ph_nxt  = ph_r;
    stg_nxt = stg_r;
    case (cw.op)
      OP_WAIT: begin
        if (in_valid) begin
          pc_nxt  = pc_r + 1'b1;
          stg_nxt = '0;
        end
      end
      OP_MUL: begin
        if (ph_r == MUL_PH_WR) begin
          ph_nxt = '0;
          pc_nxt = pc_r + 1'b1;
        end else begin
          ph_nxt = ph_r + 1'b1;
        end
      end
      OP_DIV: begin
        if (ph_r == DIV_PH_WR) begin
          ph_nxt = '0;
          pc_nxt = pc_r + 1'b1;
        end else begin
          ph_nxt = ph_r + 1'b1;
        end
      end
      OP_ADD, OP_SUB: begin
        pc_nxt = pc_r + 1'b1;
      end
      OP_JMP: begin
        pc_nxt = taken ? cw.target : pc_r + 1'b1;
        if (cw.stg_inc) begin
          stg_nxt = stg_r + 1'b1;
        end
      end
      OP_OUT: begin
        if (!out_valid_r || out_ready) begin
          pc_nxt = PC_WAIT;
        end
      end
      default: pc_nxt = PC_WAIT;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control: unit phases and the single register write port.
  // --------------------------------------------------------------------------
  always_comb begin
    m_nxt   = m_r;
    neg_nxt = neg_r;
    plo_nxt = plo_r;
    phi_nxt = phi_r;
    mr_nxt  = mr_r;
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    wr_en   = 1'b0;
    wr_val  = sat_val;
    case (cw.op)
      OP_MUL: begin
        case (ph_r)
          MUL_PH_ABS: begin
            m_nxt   = a_abs[MAG_W-1:0];
            neg_nxt = a_val[WIDE_W-1];
          end
          MUL_PH_LO:  plo_nxt = m_r[LO_BITS-1:0] * coef_val;
          MUL_PH_HI:  phi_nxt = m_r[MAG_W-1:LO_BITS] * coef_val;
          MUL_PH_SUM: begin
            mr_nxt = (|shifted[FULL_W-1:MAG_W]) ? WIDE_MAX[MAG_W-1:0]
                                                : shifted[MAG_W-1:0];
          end
          MUL_PH_WR: begin
            wr_en  = 1'b1;
            wr_val = neg_r ? -$signed({1'b0, mr_r}) : $signed({1'b0, mr_r});
          end
          default: begin
          end
        endcase
      end
      OP_DIV: begin
        if (ph_r == DIV_PH_INIT) begin
          dq_nxt  = a_abs;
          neg_nxt = a_val[WIDE_W-1];
          rem_nxt = '0;
        end else if (ph_r == DIV_PH_WR) begin
          wr_en  = 1'b1;
          wr_val = neg_r ? -$signed(q_rnd) : $signed(q_rnd);
        end else begin
          dq_nxt  = dqs;
          rem_nxt = dr[REM_W-1:0];
        end
      end
      OP_ADD, OP_SUB: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Register write-back. Speed and current saturate to the state width.
  always_comb begin
    w_nxt  = w_r;
    i_nxt  = i_r;
    v_nxt  = v_r;
    ld_nxt = ld_r;
    tw_nxt = tw_r;
    ti_nxt = ti_r;
    t_nxt  = t_r;
    u_nxt  = u_r;
    kw_nxt = kw_r;
    ki_nxt = ki_r;
    sw_nxt = sw_r;
    si_nxt = si_r;
    if (in_valid && in_ready) begin
      // The first stage evaluates the slopes at the current state.
      v_nxt  = in_drive_voltage;
      tw_nxt = w_wide;
      ti_nxt = i_wide;
    end
    if (wr_en) begin
      case (cw.dst)
        R_W:     w_nxt  = STATE_BITS'(clamp_to(wr_val, STATE_BITS));
        R_I:     i_nxt  = STATE_BITS'(clamp_to(wr_val, STATE_BITS));
        R_LD:    ld_nxt = wr_val;
        R_TW:    tw_nxt = wr_val;
        R_TI:    ti_nxt = wr_val;
        R_T:     t_nxt  = wr_val;
        R_U:     u_nxt  = wr_val;
        R_KW:    kw_nxt = wr_val;
        R_KI:    ki_nxt = wr_val;
        R_SW:    sw_nxt = wr_val;
        R_SI:    si_nxt = wr_val;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register. It is loaded at the output step and frees the datapath
  // for the next beat while the result waits for the consumer.
  // --------------------------------------------------------------------------
  assign out_load        = (cw.op == OP_OUT) && (!out_valid_r || out_ready);
  assign out_speed_nxt   = out_load ? OUT_W'(clamp_to(w_wide, OUT_W)) : out_speed_r;
  assign out_current_nxt = out_load ? OUT_W'(clamp_to(i_wide, OUT_W)) : out_current_r;

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_speed_out   = out_speed_r;
  assign out_current_out = out_current_r;

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_WAIT;
      ph_r        <= '0;
      stg_r       <= '0;
      out_valid_r <= 1'b0;
      w_r         <= '0;
      i_r         <= '0;
    end else begin
      pc_r        <= pc_nxt;
      ph_r        <= ph_nxt;
      stg_r       <= stg_nxt;
      out_valid_r <= out_valid_nxt;
      w_r         <= w_nxt;
      i_r         <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r           <= v_nxt;
    ld_r          <= ld_nxt;
    tw_r          <= tw_nxt;
    ti_r          <= ti_nxt;
    t_r           <= t_nxt;
    u_r           <= u_nxt;
    kw_r          <= kw_nxt;
    ki_r          <= ki_nxt;
    sw_r          <= sw_nxt;
    si_r          <= si_nxt;
    m_r           <= m_nxt;
    neg_r         <= neg_nxt;
    plo_r         <= plo_nxt;
    phi_r         <= phi_nxt;
    mr_r          <= mr_nxt;
    dq_r          <= dq_nxt;
    rem_r         <= rem_nxt;
    out_speed_r   <= out_speed_nxt;
    out_current_r <= out_current_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `DCM_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid),
                   "result appeared right after an input beat")
  `DCM_ASSERT_IMPL(a_result_from_out_step, $rose(out_valid), $past(cw.op == OP_OUT),
                   "result loaded outside the output step")
  `DCM_ASSERT_NEXT(a_step_after_unit_done, pc_nxt != pc_r, ph_r == '0,
                   "step advanced while a unit phase was pending")
  `DCM_ASSERT_IMPL(a_ready_with_idle_units, in_ready, ph_r == '0,
                   "input ready while a unit phase was pending")

endmodule

// ===== dv/tb_dc_motor_rk4_plant_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dc_motor_rk4_plant_step
// Self-checking bench for the DC motor RK4 plant step. Voltage ticks go in on
// a valid/ready channel and the bench predicts each new speed and current with
// its own fixed-point RK4 integrator. Results coming back are compared beat by
// beat. A short directed table comes first, followed by random phases that use
// plausible, saturating and mixed coefficient sets under several idle patterns.
// ----------------------------------------------------------------------------
module tb_dc_motor_rk4_plant_step;
  import dcm_rk4_pkg::*;

  // Signed Q16.16 working value with a 64-bit range. Every intermediate value
  // saturates at plus or minus Q_MAX.
  typedef logic signed [63:0] q_t;
  localparam q_t               Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;

  // The end of the run waits for stray beats once the last state is back.
  localparam int STEP_LATENCY = 284;
  localparam int TAIL_CYCLES  = 2 * STEP_LATENCY;
  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int N_PHASES     = 10;
  localparam int PHASE_TICKS  = 175;
  localparam int MAX_REPORTS  = 40;

  // Index 7 has no register behind it, so writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(7);

  // Voltage corners: the legal range is +-36 V, the port allows more.
  localparam logic signed [VOLT_W-1:0] V_HI     = 23'sd2359296;
  localparam logic signed [VOLT_W-1:0] V_LO     = -23'sd2359296;
  localparam logic signed [VOLT_W-1:0] V_TOP    = 23'sh3F_FFFF;
  localparam logic signed [VOLT_W-1:0] V_BOTTOM = 23'sh40_0000;
  localparam int unsigned              V_SPAN   = 2 * 2359296;

  typedef struct packed {
    logic signed [OUT_W-1:0] speed;
    logic signed [OUT_W-1:0] current;
  } motor_state_t;

  // One row of the directed table: an optional register write, the voltage of
  // the tick, and a hand-written result where one is obvious.
  typedef struct packed {
    logic                     do_cfg;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_W-1:0]         val;
    logic signed [VOLT_W-1:0] volt;
    logic                     checked;
    logic signed [OUT_W-1:0]  speed;
    logic signed [OUT_W-1:0]  current;
  } tick_row_t;

  typedef enum {SET_PLAUSIBLE, SET_CEILING, SET_FLOOR, SET_SCATTER} coef_set_t;

  localparam int N_DIRECTED = 22;
  localparam tick_row_t TICK_PLAN [N_DIRECTED] = '{
    // With a zero step size the state has to stay at its reset value of zero,
    // even for the most extreme voltages the port can carry.
    '{1'b1, CFG_TIME_STEP, 32'd0, V_TOP, 1'b1, 32'sd0, 32'sd0},
    '{1'b0, CFG_TIME_STEP, 32'd0, V_BOTTOM, 1'b1, 32'sd0, 32'sd0},
    '{1'b0, CFG_TIME_STEP, 32'd0, V_HI, 1'b1, 32'sd0, 32'sd0},
    '{1'b0, CFG_TIME_STEP, 32'd0, V_LO, 1'b1, 32'sd0, 32'sd0},
    '{1'b0, CFG_TIME_STEP, 32'd0, 23'sd0, 1'b1, 32'sd0, 32'sd0},
    // Default step: spin up at full voltage, reverse, then coast.
    '{1'b1, CFG_TIME_STEP, 32'(RST_TIME_STEP), V_HI, 1'b0, 32'sd0, 32'sd0},
    '{1'b0, CFG_TIME_STEP, 32'd0, V_HI, 1'b0, 32'sd0, 32'sd0},
    '{1'b0, CFG_TIME_STEP, 32'd0, V_HI, 1'b0, 32'sd0, 32'sd0},
    '{1'b0, CFG_TIME_STEP, 32'd0, V_LO, 1'b0, 32'sd0, 32'sd0},
    '{1'b0, CFG_TIME_STEP, 32'd0, 23'sd0, 1'b0, 32'sd0, 32'sd0},
    // A write past the register map and a write with a stray top bit.
    '{1'b1, CFG_SPARE, 32'hFFFF_FFFF, 23'sd65536, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CFG_INV_INERTIA, 32'h9400_0000, V_TOP, 1'b0, 32'sd0, 32'sd0},
    // Load torque at both ends of its signed range.
    '{1'b1, CFG_LOAD_TORQUE, 32'h8000_0000, 23'sd0, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CFG_LOAD_TORQUE, 32'h7FFF_FFFF, 23'sd0, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CFG_TORQUE_CONST, 32'hFFFF_FFFF, V_BOTTOM, 1'b0, 32'sd0, 32'sd0},
    // A huge step drives every stage into saturation and the state to a rail.
    '{1'b1, CFG_TIME_STEP, 32'h7FFF_FFFF, V_TOP, 1'b0, 32'sd0, 32'sd0},
    '{1'b0, CFG_TIME_STEP, 32'd0, V_BOTTOM, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CFG_INV_INDUCTANCE, 32'd0, V_TOP, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CFG_RESISTANCE, 32'h7FFF_FFFF, V_LO, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CFG_FRICTION, 32'h7FFF_FFFF, V_HI, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CFG_INV_INERTIA, 32'd0, 23'sd0, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CFG_TIME_STEP, 32'd0, V_TOP, 1'b0, 32'sd0, 32'sd0}
  };

  // All inputs hold known values from time zero.
  logic                     clk              = 1'b0;
  logic                     rst_n            = 1'b0;
  logic                     in_valid         = 1'b0;
  logic                     in_ready;
  logic signed [VOLT_W-1:0] in_drive_voltage = '0;
  logic                     out_valid;
  logic                     out_ready        = 1'b0;
  logic signed [OUT_W-1:0]  out_speed_out;
  logic signed [OUT_W-1:0]  out_current_out;
  logic                     cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index        = '0;
  logic [CFG_W-1:0]         cfg_wdata        = '0;

  dc_motor_rk4_plant_step dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_drive_voltage (in_drive_voltage),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_speed_out    (out_speed_out),
    .out_current_out  (out_current_out),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the plant: coefficients as the block holds them, and the
  // speed and current at full state width.
  logic [COEF_W-1:0]        coef_inv_j;
  logic [COEF_W-1:0]        coef_inv_l;
  logic [COEF_W-1:0]        coef_res;
  logic [COEF_W-1:0]        coef_fric;
  logic [COEF_W-1:0]        coef_kt;
  logic [COEF_W-1:0]        coef_step;
  logic signed [LOAD_W-1:0] coef_load;
  q_t                       plant_speed;
  q_t                       plant_current;

  // New states that the block still owes, oldest first.
  motor_state_t owed_states [$];

  int sender_idle_pct  = 0;
  int receiver_idle_pct = 0;
  int stall_left       = 0;
  int cycle_count      = 0;
  int ticks_sent       = 0;
  int states_checked   = 0;
  int coef_sets        = 0;
  int error_count      = 0;

  // --------------------------------------------------------------------------
  // Fixed-point helpers
  // --------------------------------------------------------------------------

  function automatic q_t sum_sat(input q_t a, input q_t b);
    logic signed [64:0] t;
    t = a + b;
    if (t > SUM_HI) return Q_MAX;
    if (t < -SUM_HI) return -Q_MAX;
    return q_t'(t);
  endfunction

  // (a * c) >> s, rounded half away from zero, saturated. The full product
  // fits in 96 bits, so it is formed exactly and shifted in one go.
  function automatic q_t scale_q(input q_t a, input logic [31:0] c, input int s);
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [63:0]  r;
    mag  = a[63] ? -a : a;
    prod = (128'(mag) * 128'(c) + (128'd1 << (s - 1))) >> s;
    r    = (prod > 128'(Q_MAX)) ? Q_MAX : prod[63:0];
    return a[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic q_t div6_round(input q_t a);
    logic [63:0] mag;
    logic [63:0] q;
    mag = a[63] ? -a : a;
    q   = mag / 64'd6 + (((mag % 64'd6) >= 64'd3) ? 64'd1 : 64'd0);
    return a[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic q_t sat_bits(input q_t a, input int bits);
    q_t hi;
    hi = (q_t'(1) <<< (bits - 1)) - q_t'(1);
    if (a > hi) return hi;
    if (a < -hi - q_t'(1)) return -hi - q_t'(1);
    return a;
  endfunction

  // Speed and current slopes at one stage point.
  function automatic void motor_slopes(input q_t w, input q_t i, input q_t v,
                                       output q_t dw, output q_t di);
    q_t load_q;
    q_t t;
    load_q = scale_q(q_t'(coef_load), 32'h0001_0000, 24);
    t  = sum_sat(scale_q(i, coef_kt, 24), -scale_q(w, coef_fric, 24));
    t  = sum_sat(t, -load_q);
    dw = scale_q(t, coef_inv_j, 24);
    t  = sum_sat(v, -scale_q(w, coef_kt, 24));
    t  = sum_sat(t, -scale_q(i, coef_res, 24));
    di = scale_q(t, coef_inv_l, 24);
  endfunction

  // x + (d1 + 2*d2 + 2*d3 + d4) / 6 with dN = h * kN.
  function automatic q_t rk4_merge(input q_t x, input q_t k1, input q_t k2,
                                   input q_t k3, input q_t k4);
    q_t d2;
    q_t d3;
    q_t s;
    d2 = scale_q(k2, coef_step, 24);
    d3 = scale_q(k3, coef_step, 24);
    s  = sum_sat(scale_q(k1, coef_step, 24), sum_sat(d2, d2));
    s  = sum_sat(s, sum_sat(d3, d3));
    s  = sum_sat(s, scale_q(k4, coef_step, 24));
    return sat_bits(sum_sat(x, div6_round(s)), STATE_BITS);
  endfunction

  // Advance the shadow plant by one tick and return what the block must send.
  task automatic rk4_tick(input logic signed [VOLT_W-1:0] volt,
                          output motor_state_t after);
    q_t v;
    q_t w;
    q_t i;
    q_t kw1, ki1, kw2, ki2, kw3, ki3, kw4, ki4;
    q_t out_w;
    q_t out_i;
    v = q_t'(volt);
    w = plant_speed;
    i = plant_current;
    // The first two midpoints use half a step, hence the shift by 25.
    motor_slopes(w, i, v, kw1, ki1);
    motor_slopes(sum_sat(w, scale_q(kw1, coef_step, 25)),
                 sum_sat(i, scale_q(ki1, coef_step, 25)), v, kw2, ki2);
    motor_slopes(sum_sat(w, scale_q(kw2, coef_step, 25)),
                 sum_sat(i, scale_q(ki2, coef_step, 25)), v, kw3, ki3);
    motor_slopes(sum_sat(w, scale_q(kw3, coef_step, 24)),
                 sum_sat(i, scale_q(ki3, coef_step, 24)), v, kw4, ki4);
    plant_speed   = rk4_merge(w, kw1, kw2, kw3, kw4);
    plant_current = rk4_merge(i, ki1, ki2, ki3, ki4);
    out_w = sat_bits(plant_speed, OUT_W);
    out_i = sat_bits(plant_current, OUT_W);
    after.speed   = out_w[OUT_W-1:0];
    after.current = out_i[OUT_W-1:0];
  endtask

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------

  // Drive one register write for the next edge and mirror it in the shadow.
  // The caller lowers cfg_we once its group of writes is done, so that a run
  // of writes keeps the enable high without a glitch in between.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_INV_INERTIA:    coef_inv_j = data[COEF_W-1:0];
      CFG_INV_INDUCTANCE: coef_inv_l = data[COEF_W-1:0];
      CFG_RESISTANCE:     coef_res   = data[COEF_W-1:0];
      CFG_FRICTION:       coef_fric  = data[COEF_W-1:0];
      CFG_TORQUE_CONST:   coef_kt    = data[COEF_W-1:0];
      CFG_LOAD_TORQUE:    coef_load  = data;
      CFG_TIME_STEP:      coef_step  = data[COEF_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Register value for one phase. Plausible sets stay near the default motor
  // so that the integration remains stable; the top bit of 31-bit registers is
  // filled at random since the block must drop it.
  function automatic logic [CFG_W-1:0] pick_coef(input coef_set_t kind,
                                                input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_W-1:0] val;
    logic             is_load;
    is_load = (idx == CFG_LOAD_TORQUE);
    case (kind)
      SET_CEILING: val = is_load ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
      SET_FLOOR:   val = is_load ? 32'h8000_0000 : 32'h0000_0000;
      SET_SCATTER: begin
        case ($urandom_range(0, 2))
          0:       val = is_load ? 32'h8000_0000 : 32'h0000_0000;
          1:       val = is_load ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
          default: val = $urandom();
        endcase
      end
      default: begin
        case (idx)
          CFG_INV_INERTIA:    val = $urandom_range(83886080, 671088640);
          CFG_INV_INDUCTANCE: val = $urandom_range(33554432, 335544320);
          CFG_RESISTANCE:     val = $urandom_range(0, 16777216);
          CFG_FRICTION:       val = $urandom_range(0, 167772);
          CFG_TORQUE_CONST:   val = $urandom_range(838860, 25165824);
          CFG_LOAD_TORQUE:    val = $urandom_range(0, 33554432) - 32'd16777216;
          default:            val = $urandom_range(16777, 335544);
        endcase
        if (!is_load) val[CFG_W-1] = $urandom_range(0, 1);
      end
    endcase
    return val;
  endfunction

  // --------------------------------------------------------------------------
  // Input channel
  // --------------------------------------------------------------------------

  // Lower valid and wait until every owed state has come back, so that the
  // block sits idle before its registers are touched.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (owed_states.size() != 0) @(posedge clk);
  endtask

  // Offer one tick and wait for its handshake. Valid stays high after the beat
  // unless the next call opens a gap, so back-to-back ticks need no dip.
  task automatic send_tick(input logic signed [VOLT_W-1:0] volt, input bit typed,
                           input logic signed [OUT_W-1:0] typed_speed,
                           input logic signed [OUT_W-1:0] typed_current);
    motor_state_t after;
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid         <= 1'b1;
    in_drive_voltage <= volt;
    do @(posedge clk); while (!in_ready);
    rk4_tick(volt, after);
    if (typed) begin
      after.speed   = typed_speed;
      after.current = typed_current;
    end
    owed_states.push_back(after);
    ticks_sent++;
  endtask

  // Random voltage: mostly in the legal range, some held over from the last
  // tick the way a controller would, some corners and some raw port values.
  function automatic logic signed [VOLT_W-1:0] pick_voltage(
    input logic signed [VOLT_W-1:0] last);
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0:       return V_HI;
          1:       return V_LO;
          2:       return V_TOP;
          default: return V_BOTTOM;
        endcase
      end
      2, 3, 4: return last;
      default: return $urandom_range(0, V_SPAN) - V_SPAN / 2;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result channel
  // --------------------------------------------------------------------------

  task automatic report_field(input string field, input logic signed [OUT_W-1:0] want,
                              input logic signed [OUT_W-1:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  task automatic check_state(input logic signed [OUT_W-1:0] speed,
                             input logic signed [OUT_W-1:0] current);
    motor_state_t want;
    if (owed_states.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: unexpected beat, expected none, got speed %0d current %0d",
                 $time, speed, current);
    end else begin
      want = owed_states.pop_front();
      report_field("speed_out", want.speed, speed);
      report_field("current_out", want.current, current);
      states_checked++;
    end
  endtask

  // Outputs are sampled at the edge, before the block's own updates land.
  // When the receiver is set to stall it also starts, now and then, a long
  // stall that can outlast a whole tick, so the sequencer may have to hold at its
  // output step with the next state finished.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) check_state(out_speed_out, out_current_out);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (receiver_idle_pct != 0 && $urandom_range(0, 1023) == 0) begin
      stall_left = $urandom_range(100, 700);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles, %0d states still owed",
             $time, cycle_count, owed_states.size());
    $display("** dc_motor_rk4_plant_step: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic signed [VOLT_W-1:0] volt;
    coef_set_t                kind;
    int                       phase;
    int                       row;

    // Shadow starts from the register defaults and a motor at rest.
    coef_inv_j    = RST_INV_INERTIA;
    coef_inv_l    = RST_INV_INDUCTANCE;
    coef_res      = RST_RESISTANCE;
    coef_fric     = RST_FRICTION;
    coef_kt       = RST_TORQUE_CONST;
    coef_load     = RST_LOAD_TORQUE;
    coef_step     = RST_TIME_STEP;
    plant_speed   = '0;
    plant_current = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling on either side.
    for (row = 0; row < N_DIRECTED; row++) begin
      if (TICK_PLAN[row].do_cfg) begin
        settle_block();
        cfg_write(TICK_PLAN[row].idx, TICK_PLAN[row].val);
        cfg_we <= 1'b0;
        coef_sets++;
      end
      send_tick(TICK_PLAN[row].volt, TICK_PLAN[row].checked,
                TICK_PLAN[row].speed, TICK_PLAN[row].current);
    end

    // Random phases. Each one loads a full coefficient set while the block is
    // idle, then streams ticks under one of four idle patterns. Phase zero
    // runs with no idling at all.
    volt = '0;
    for (phase = 0; phase < N_PHASES; phase++) begin
      settle_block();
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
        1: begin sender_idle_pct = 70; receiver_idle_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_idle_pct = 70; end
        default: begin sender_idle_pct = 26; receiver_idle_pct = 26; end
      endcase
      case (phase)
        2:       kind = SET_CEILING;
        5:       kind = SET_FLOOR;
        8:       kind = SET_SCATTER;
        default: kind = SET_PLAUSIBLE;
      endcase
      for (int r = 0; r <= int'(CFG_TIME_STEP); r++)
        cfg_write(CFG_IDX_W'(r), pick_coef(kind, CFG_IDX_W'(r)));
      cfg_we <= 1'b0;
      coef_sets++;
      repeat (PHASE_TICKS) begin
        volt = pick_voltage(volt);
        send_tick(volt, 1'b0, '0, '0);
      end
    end

    // Drain, then give the block time to show any beat it should not send.
    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d ticks (%0d from the directed table) and checked %0d states,",
             ticks_sent, N_DIRECTED, states_checked);
    $display("across %0d coefficient changes in %0d cycles; %0d mismatches.",
             coef_sets, cycle_count, error_count);
    if (error_count == 0) begin
      $display("** dc_motor_rk4_plant_step: PASSED **");
    end else begin
      $display("** dc_motor_rk4_plant_step: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dcm_rk4_pkg.sv
rtl/dc_motor_rk4_plant_step.sv
dv/tb_dc_motor_rk4_plant_step.sv
